@@ design/tsgd_pkg.sv @@
// ----------------------------------------------------------------------------
// tsgd_pkg
// Shared types and constants of the three-phase sine gimbal drive.
// ----------------------------------------------------------------------------
package tsgd_pkg;

	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int NUM_MOTORS_DEF      = 3;
	localparam int MAX_MOTORS          = 3;
	localparam int WINDINGS            = 3;

	// fifth-order quadrant sine, Q15
	localparam logic [15:0] SIN_A = 16'd51472;
	localparam logic [15:0] SIN_B = 16'd21024;
	localparam logic [23:0] SIN_C = 24'd2320;

	// floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 2^24
	localparam logic [24:0] RECIP_100   = 25'd21474837;
	localparam int          RECIP_SHIFT = 31;

	localparam logic [31:0] ACCEL_RST = 32'd35791394;
	localparam logic [14:0] HALF_RST  = 15'd300;

	localparam logic [31:0] WINDING_OFFSET [WINDINGS] = '{
		32'd0, 32'd1431655765, 32'd2863311531
	};

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_SPEED = 2'd1,
		CMD_LAG   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_SCALE_ROLL   = 3'd0,
		REG_SCALE_PITCH  = 3'd1,
		REG_SCALE_YAW    = 3'd2,
		REG_ACCEL_ROLL   = 3'd3,
		REG_ACCEL_PITCH  = 3'd4,
		REG_ACCEL_YAW    = 3'd5,
		REG_HALF_PERIOD  = 3'd6,
		REG_OUTPUT_COUNT = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic        start;
		logic [31:0] angle;
		logic [7:0]  scale;
		logic [14:0] half_period;
	} calc_req_t;

	typedef struct packed {
		logic        valid;
		logic [15:0] compare;
	} calc_rsp_t;

endpackage

@@ design/tsgd_sine_unit.sv @@
// ----------------------------------------------------------------------------
// tsgd_sine_unit
// Angle to PWM compare value: quadrant sine polynomial, level and percent
// scaling, stepped through one shared multiplier.
// ----------------------------------------------------------------------------
module tsgd_sine_unit #(
	parameter int SINE_TABLE_BITS = tsgd_pkg::SINE_TABLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tsgd_pkg::calc_req_t req,
	output tsgd_pkg::calc_rsp_t rsp
);

	localparam int RW   = SINE_TABLE_BITS - 2;
	localparam int ZPAD = 17 - SINE_TABLE_BITS;

	typedef enum logic [8:0] {
		U_IDLE = 9'b000000001,
		U_SQ   = 9'b000000010,
		U_CZ   = 9'b000000100,
		U_BT   = 9'b000001000,
		U_AT   = 9'b000010000,
		U_LVL  = 9'b000100000,
		U_SCL  = 9'b001000000,
		U_RCP  = 9'b010000000,
		U_FIN  = 9'b100000000
	} ustate_t;

	ustate_t     ustate_q, ustate_d;
	logic [31:0] angle_q;
	logic [7:0]  scale_q;
	logic [14:0] half_q;
	logic [15:0] z2_q;
	logic [48:0] p_q;
	logic [15:0] cmp_q;
	logic        vld_q;

	logic [15:0] z_raw, z, p_mid, t_b, t_a, s_cap, sv;
	logic [17:0] qv;
	logic [15:0] cmp_sat;
	logic [23:0] mul_a;
	logic [24:0] mul_b;
	logic [48:0] mul;

	assign z_raw = {1'b0, angle_q[29 -: RW], {ZPAD{1'b0}}};
	assign z     = angle_q[30] ? (16'h8000 - z_raw) : z_raw;
	assign p_mid = p_q[30:15];
	assign t_b   = tsgd_pkg::SIN_B - p_mid;
	assign t_a   = tsgd_pkg::SIN_A - p_mid;
	assign s_cap = (p_mid > 16'd32767) ? 16'd32767 : p_mid;
	assign sv    = angle_q[31] ? (16'h8000 - s_cap) : (16'h8000 + s_cap);
	assign qv    = p_q[48:tsgd_pkg::RECIP_SHIFT];
	assign cmp_sat = (qv > 18'd65535) ? 16'hFFFF : qv[15:0];

	always_comb begin
		case (ustate_q)
			U_SQ: begin
				mul_a = 24'(z);
				mul_b = 25'(z);
			end
			U_CZ: begin
				mul_a = tsgd_pkg::SIN_C;
				mul_b = 25'(p_mid);
			end
			U_BT: begin
				mul_a = 24'(t_b);
				mul_b = 25'(z2_q);
			end
			U_AT: begin
				mul_a = 24'(t_a);
				mul_b = 25'(z);
			end
			U_LVL: begin
				mul_a = 24'(half_q);
				mul_b = 25'(sv);
			end
			U_SCL: begin
				mul_a = 24'(scale_q);
				mul_b = 25'(p_mid);
			end
			U_RCP: begin
				mul_a = p_q[23:0];
				mul_b = tsgd_pkg::RECIP_100;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul = 49'(mul_a) * 49'(mul_b);

	always_comb begin
		case (ustate_q)
			U_IDLE:  ustate_d = req.start ? U_SQ : U_IDLE;
			U_SQ:    ustate_d = U_CZ;
			U_CZ:    ustate_d = U_BT;
			U_BT:    ustate_d = U_AT;
			U_AT:    ustate_d = U_LVL;
			U_LVL:   ustate_d = U_SCL;
			U_SCL:   ustate_d = U_RCP;
			U_RCP:   ustate_d = U_FIN;
			default: ustate_d = U_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ustate_q <= U_IDLE;
			vld_q    <= 1'b0;
		end else begin
			ustate_q <= ustate_d;
			if (req.start) begin
				vld_q <= 1'b0;
			end else if (ustate_q == U_FIN) begin
				vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			angle_q <= req.angle;
			scale_q <= req.scale;
			half_q  <= req.half_period;
		end
		if (ustate_q == U_CZ) begin
			z2_q <= p_mid;
		end
		if (ustate_q != U_IDLE && ustate_q != U_FIN) begin
			p_q <= mul;
		end
		if (ustate_q == U_FIN) begin
			cmp_q <= cmp_sat;
		end
	end

	assign rsp.valid   = vld_q;
	assign rsp.compare = cmp_q;

endmodule

@@ design/three_phase_sine_gimbal_drive_unit.sv @@
// ----------------------------------------------------------------------------
// three_phase_sine_gimbal_drive_unit
// Open-loop sine commutation of up to three gimbal motors, three windings each.
// ----------------------------------------------------------------------------
// Each word on the input stream is a tick, a set-speed or a set-lag command;
// other command codes, and set words for an absent channel, are taken and
// dropped. Per-channel phase, speed and lag live in a small synchronous memory
// whose entries read as zero until first written, so no clearing pass follows
// reset. A tick advances the phase of every channel and emits a compare value
// for each winding of each served channel; each value takes the eight-step
// sequence through the sine unit's single multiplier plus its start and
// hand-off, and a stalled output stream stretches the wait. Results leave
// through an output register, so the next input word is taken while the last
// result waits.
module three_phase_sine_gimbal_drive_unit #(
	parameter int SINE_TABLE_BITS = tsgd_pkg::SINE_TABLE_BITS_DEF,
	parameter int NUM_MOTORS      = tsgd_pkg::NUM_MOTORS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // channel[1:0], value[33:2], step_time[49:34]
	input  logic [1:0]  s_axis_tuser,  // command[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // compare[15:0]
	output logic [3:0]  m_axis_tuser,  // motor[1:0], winding[3:2]
	output logic        m_axis_tlast
);

	localparam int CH_W  = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int ENT_W = 96;
	localparam logic [1:0] LAST_CH = 2'(NUM_MOTORS - 1);
	localparam logic [1:0] LAST_WD = 2'(tsgd_pkg::WINDINGS - 1);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SLEW  = 7'b0000010,
		ST_SPDW  = 7'b0000100,
		ST_LAGW  = 7'b0001000,
		ST_ADV   = 7'b0010000,
		ST_START = 7'b0100000,
		ST_WAIT  = 7'b1000000
	} state_t;

	function automatic logic served(input logic [1:0] c, input logic [3:0] n);
		return ((5'(c) + 5'd1) * 5'(tsgd_pkg::WINDINGS)) <= {1'b0, n};
	endfunction

	// configuration
	logic [7:0]  scale_q [tsgd_pkg::MAX_MOTORS];
	logic [31:0] accel_q [tsgd_pkg::MAX_MOTORS];
	logic [14:0] half_q;
	logic [3:0]  count_q;
	logic        cfg_we;
	tsgd_pkg::reg_idx_t cfg_idx;

	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign cfg_idx = tsgd_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tsgd_pkg::MAX_MOTORS; i++) begin
				scale_q[i] <= '0;
				accel_q[i] <= tsgd_pkg::ACCEL_RST;
			end
			half_q  <= tsgd_pkg::HALF_RST;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				tsgd_pkg::REG_SCALE_ROLL:   scale_q[0] <= pwdata[7:0];
				tsgd_pkg::REG_SCALE_PITCH:  scale_q[1] <= pwdata[7:0];
				tsgd_pkg::REG_SCALE_YAW:    scale_q[2] <= pwdata[7:0];
				tsgd_pkg::REG_ACCEL_ROLL:   accel_q[0] <= pwdata;
				tsgd_pkg::REG_ACCEL_PITCH:  accel_q[1] <= pwdata;
				tsgd_pkg::REG_ACCEL_YAW:    accel_q[2] <= pwdata;
				tsgd_pkg::REG_HALF_PERIOD:  half_q     <= pwdata[14:0];
				tsgd_pkg::REG_OUTPUT_COUNT: count_q    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			tsgd_pkg::REG_SCALE_ROLL:   prdata = 32'(scale_q[0]);
			tsgd_pkg::REG_SCALE_PITCH:  prdata = 32'(scale_q[1]);
			tsgd_pkg::REG_SCALE_YAW:    prdata = 32'(scale_q[2]);
			tsgd_pkg::REG_ACCEL_ROLL:   prdata = accel_q[0];
			tsgd_pkg::REG_ACCEL_PITCH:  prdata = accel_q[1];
			tsgd_pkg::REG_ACCEL_YAW:    prdata = accel_q[2];
			tsgd_pkg::REG_HALF_PERIOD:  prdata = 32'(half_q);
			tsgd_pkg::REG_OUTPUT_COUNT: prdata = 32'(count_q);
			default:                    prdata = '0;
		endcase
	end

	// input word
	logic              in_acc, in_ch_ok;
	tsgd_pkg::cmd_t    in_cmd;
	logic [1:0]        in_ch;
	logic [31:0]       in_val;
	logic [15:0]       in_st;

	assign in_acc   = s_axis_tvalid & s_axis_tready;
	assign in_cmd   = tsgd_pkg::cmd_t'(s_axis_tuser);
	assign in_ch    = s_axis_tdata[1:0];
	assign in_val   = s_axis_tdata[33:2];
	assign in_st    = s_axis_tdata[49:34];
	assign in_ch_ok = int'(in_ch) < NUM_MOTORS;

	// state memory: {lag, speed, phase}
	logic [ENT_W-1:0]      ent_mem [NUM_MOTORS];
	logic [ENT_W-1:0]      rd_data_q, ent, wr_data;
	logic [NUM_MOTORS-1:0] ent_vld_q;
	logic                  rd_ok_q, rd_en, wr_en;
	logic [CH_W-1:0]       rd_addr, wr_addr;
	logic [31:0]           phase, speed, lag;

	assign ent   = rd_ok_q ? rd_data_q : '0;
	assign phase = ent[31:0];
	assign speed = ent[63:32];
	assign lag   = ent[95:64];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= ent_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				ent_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= ent_vld_q[rd_addr];
			end
		end
	end

	// sequencer
	state_t             state_q, state_d;
	logic [1:0]         ch_q, c_q, w_q, next_ch;
	logic [31:0]        val_q, base_q, lim_q, phase_new, spd_new;
	logic [15:0]        st_q;
	logic signed [32:0] diff_q, diff_d;
	logic signed [33:0] lim_s, diff_s, clamp;
	logic [47:0]        slew_prod;
	logic               load, start, out_free, out_last;

	logic        out_vld_q, out_last_q;
	logic [1:0]  out_motor_q, out_wind_q;
	logic [15:0] out_cmp_q;

	tsgd_pkg::calc_req_t req;
	tsgd_pkg::calc_rsp_t rsp;

	assign next_ch   = c_q + 2'd1;
	assign phase_new = phase + speed;
	assign slew_prod = 48'(accel_q[ch_q]) * 48'(st_q);
	assign diff_d    = $signed({val_q[31], val_q}) - $signed({speed[31], speed});
	assign lim_s     = $signed({2'b00, lim_q});
	assign diff_s    = $signed({diff_q[32], diff_q});
	assign clamp     = (diff_s > lim_s) ? lim_s : ((diff_s < -lim_s) ? -lim_s : diff_s);
	assign spd_new   = speed + clamp[31:0];
	assign out_free  = !out_vld_q || m_axis_tready;
	assign out_last  = (w_q == LAST_WD) && ((c_q == LAST_CH) || !served(next_ch, count_q));

	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = CH_W'(next_ch);
		wr_en   = 1'b0;
		wr_addr = CH_W'(c_q);
		wr_data = {lag, speed, phase_new};
		load    = 1'b0;
		start   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (in_cmd == tsgd_pkg::CMD_TICK) begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = ST_ADV;
					end else if (in_cmd == tsgd_pkg::CMD_SPEED && in_ch_ok) begin
						rd_en   = 1'b1;
						rd_addr = CH_W'(in_ch);
						state_d = ST_SLEW;
					end else if (in_cmd == tsgd_pkg::CMD_LAG && in_ch_ok) begin
						rd_en   = 1'b1;
						rd_addr = CH_W'(in_ch);
						state_d = ST_LAGW;
					end
				end
			end
			ST_SLEW: state_d = ST_SPDW;
			ST_SPDW: begin
				wr_en   = 1'b1;
				wr_addr = CH_W'(ch_q);
				wr_data = {lag, spd_new, phase};
				state_d = ST_IDLE;
			end
			ST_LAGW: begin
				wr_en   = 1'b1;
				wr_addr = CH_W'(ch_q);
				wr_data = {val_q, speed, phase};
				state_d = ST_IDLE;
			end
			ST_ADV: begin
				wr_en = 1'b1;
				if (served(c_q, count_q)) begin
					state_d = ST_START;
				end else if (c_q == LAST_CH) begin
					state_d = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					state_d = ST_ADV;
				end
			end
			ST_START: begin
				start   = 1'b1;
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (rsp.valid && out_free) begin
					load = 1'b1;
					if (w_q != LAST_WD) begin
						state_d = ST_START;
					end else if (c_q == LAST_CH) begin
						state_d = ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						state_d = ST_ADV;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			c_q       <= '0;
			w_q       <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				c_q <= '0;
			end else if (rd_en) begin
				c_q <= next_ch;
			end
			if (state_q == ST_ADV) begin
				w_q <= '0;
			end else if (load) begin
				w_q <= w_q + 2'd1;
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			ch_q  <= in_ch;
			val_q <= in_val;
			st_q  <= in_st;
		end
		if (state_q == ST_SLEW) begin
			diff_q <= diff_d;
			lim_q  <= slew_prod[47:16];
		end
		if (state_q == ST_ADV) begin
			base_q <= phase_new + lag;
		end
		if (load) begin
			out_motor_q <= c_q;
			out_wind_q  <= w_q;
			out_cmp_q   <= rsp.compare;
			out_last_q  <= out_last;
		end
	end

	assign req.start       = start;
	assign req.angle       = base_q + tsgd_pkg::WINDING_OFFSET[w_q];
	assign req.scale       = scale_q[c_q];
	assign req.half_period = half_q;

	tsgd_sine_unit #(
		.SINE_TABLE_BITS(SINE_TABLE_BITS)
	) u_sine (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_cmp_q;
	assign m_axis_tuser  = {out_wind_q, out_motor_q};
	assign m_axis_tlast  = out_last_q;

	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("state memory read and write hit the same entry");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result loaded over a word not yet taken");

	// unserved channels after the last result still get their phase advanced
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load && out_last) |=> (state_q == ST_IDLE || state_q == ST_ADV))
		else $error("tick went on to another result after its last");

	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START) |=> !rsp.valid)
		else $error("sine unit kept a stale result after start");

endmodule

@@ tb/tb_three_phase_sine_gimbal_drive_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_phase_sine_gimbal_drive_unit
// Drives command words and register writes into the gimbal drive, predicts
// every compare word from its own copy of speed, phase and lag, and checks
// the output stream in order. Register writes are read back as well.
// ----------------------------------------------------------------------------
module tb_three_phase_sine_gimbal_drive_unit;

	localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
	localparam logic [1:0] CH_INVALID   = 2'd3;
	localparam int         TBL_BITS     = tsgd_pkg::SINE_TABLE_BITS_DEF;
	localparam int         N_MOTORS     = tsgd_pkg::NUM_MOTORS_DEF;
	localparam int         DRAIN_CYCLES = 120;
	localparam int         RAND_PHASES  = 6;
	localparam int         WORDS_PER_PHASE = 68;

	typedef struct packed {
		logic [1:0]  motor;
		logic [1:0]  winding;
		logic [15:0] compare;
		logic        last;
	} drive_word_t;

	class drive_scoreboard;
		bit [7:0]    scale [3];
		bit [31:0]   accel [3];
		bit [14:0]   half_per;
		bit [3:0]    out_count;
		bit [31:0]   phase [3];
		bit [31:0]   speed [3];
		bit [31:0]   lag_turn [3];
		drive_word_t compare_q [$];
		int          errors;

		function new();
			for (int i = 0; i < 3; i++) begin
				scale[i]    = '0;
				accel[i]    = tsgd_pkg::ACCEL_RST;
				phase[i]    = '0;
				speed[i]    = '0;
				lag_turn[i] = '0;
			end
			half_per  = tsgd_pkg::HALF_RST;
			out_count = '0;
			errors    = 0;
		endfunction

		function void set_reg(tsgd_pkg::reg_idx_t idx, bit [31:0] data);
			case (idx)
				tsgd_pkg::REG_SCALE_ROLL, tsgd_pkg::REG_SCALE_PITCH,
				tsgd_pkg::REG_SCALE_YAW: begin
					scale[idx - tsgd_pkg::REG_SCALE_ROLL] = data[7:0];
				end
				tsgd_pkg::REG_ACCEL_ROLL, tsgd_pkg::REG_ACCEL_PITCH,
				tsgd_pkg::REG_ACCEL_YAW: begin
					accel[idx - tsgd_pkg::REG_ACCEL_ROLL] = data;
				end
				tsgd_pkg::REG_HALF_PERIOD: half_per = data[14:0];
				default: out_count = data[3:0];
			endcase
		endfunction

		function bit [31:0] reg_value(tsgd_pkg::reg_idx_t idx);
			case (idx)
				tsgd_pkg::REG_SCALE_ROLL, tsgd_pkg::REG_SCALE_PITCH,
				tsgd_pkg::REG_SCALE_YAW: begin
					return {24'd0, scale[idx - tsgd_pkg::REG_SCALE_ROLL]};
				end
				tsgd_pkg::REG_ACCEL_ROLL, tsgd_pkg::REG_ACCEL_PITCH,
				tsgd_pkg::REG_ACCEL_YAW: begin
					return accel[idx - tsgd_pkg::REG_ACCEL_ROLL];
				end
				tsgd_pkg::REG_HALF_PERIOD: return {17'd0, half_per};
				default: return {28'd0, out_count};
			endcase
		endfunction

		// Q15 sine of a turn angle, quadrant polynomial
		function int sine_of_turn(bit [31:0] angle);
			bit [31:0] idx, quad, z, z2, t;
			idx  = angle >> (32 - TBL_BITS);
			quad = (idx >> (TBL_BITS - 2)) & 32'd3;
			z    = (idx & ((32'd1 << (TBL_BITS - 2)) - 32'd1)) << (17 - TBL_BITS);
			if (quad[0])
				z = 32'd32768 - z;
			z2 = (z * z) >> 15;
			t  = (32'(tsgd_pkg::SIN_C) * z2) >> 15;
			t  = 32'(tsgd_pkg::SIN_B) - t;
			t  = (t * z2) >> 15;
			t  = 32'(tsgd_pkg::SIN_A) - t;
			t  = (t * z) >> 15;
			if (t > 32'd32767)
				t = 32'd32767;
			return quad[1] ? -int'(t) : int'(t);
		endfunction

		function void note_input(logic [1:0] cmd, logic [1:0] ch, logic [31:0] val,
				logic [15:0] st);
			longint      diff, lim, level, cmp;
			int          sv;
			int          n;
			bit [31:0]   angle;
			drive_word_t batch [9];
			n = 0;
			case (cmd)
				tsgd_pkg::CMD_SPEED: begin
					if (ch < N_MOTORS) begin
						diff = $signed(val) - $signed(speed[ch]);
						lim  = ({32'd0, accel[ch]} * {48'd0, st}) >> 16;
						if (diff > lim)
							diff = lim;
						if (diff < -lim)
							diff = -lim;
						speed[ch] = speed[ch] + diff[31:0];
					end
				end
				tsgd_pkg::CMD_LAG: begin
					if (ch < N_MOTORS)
						lag_turn[ch] = val;
				end
				tsgd_pkg::CMD_TICK: begin
					for (int c = 0; c < N_MOTORS; c++) begin
						phase[c] = phase[c] + speed[c];
						if (3 * (c + 1) <= out_count) begin
							for (int w = 0; w < tsgd_pkg::WINDINGS; w++) begin
								angle = phase[c] + lag_turn[c] + tsgd_pkg::WINDING_OFFSET[w];
								sv    = sine_of_turn(angle);
								level = (longint'(half_per) * longint'(32768 + sv)) >> 15;
								cmp   = (longint'(scale[c]) * level) / 100;
								if (cmp > 65535)
									cmp = 65535;
								batch[n] = '{motor: c[1:0], winding: w[1:0],
									compare: cmp[15:0], last: 1'b0};
								n++;
							end
						end
					end
					for (int i = 0; i < n; i++) begin
						if (i == n - 1)
							batch[i].last = 1'b1;
						compare_q.push_back(batch[i]);
					end
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		task check_result(drive_word_t got);
			drive_word_t want;
			if (compare_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word motor %0d winding %0d compare %0d",
					got.motor, got.winding, got.compare));
			end else begin
				want = compare_q.pop_front();
				if (got.motor !== want.motor)
					report_mismatch($sformatf("motor %0d, want %0d", got.motor, want.motor));
				if (got.winding !== want.winding)
					report_mismatch($sformatf("winding %0d, want %0d",
						got.winding, want.winding));
				if (got.compare !== want.compare)
					report_mismatch($sformatf("compare %0d, want %0d (motor %0d winding %0d)",
						got.compare, want.compare, want.motor, want.winding));
				if (got.last !== want.last)
					report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;   // channel[1:0], value[33:2], step_time[49:34]
	logic [1:0]  s_axis_tuser;   // command[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // compare[15:0]
	logic [3:0]  m_axis_tuser;   // motor[1:0], winding[3:2]
	logic        m_axis_tlast;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	drive_scoreboard sb;

	three_phase_sine_gimbal_drive_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result('{motor: m_axis_tuser[1:0], winding: m_axis_tuser[3:2],
				compare: m_axis_tdata, last: m_axis_tlast});
	end

	task automatic apb_write(tsgd_pkg::reg_idx_t idx, logic [31:0] data);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, data);
		// read back
		@(negedge clk);
		penable = 1'b0;
		pwrite  = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.reg_value(idx))
			sb.report_mismatch($sformatf("register %s reads %0h, want %0h",
				idx.name(), prdata, sb.reg_value(idx)));
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic write_all(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
			logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
			logic [31:0] hp, logic [31:0] cnt);
		apb_write(tsgd_pkg::REG_SCALE_ROLL, s0);
		apb_write(tsgd_pkg::REG_SCALE_PITCH, s1);
		apb_write(tsgd_pkg::REG_SCALE_YAW, s2);
		apb_write(tsgd_pkg::REG_ACCEL_ROLL, a0);
		apb_write(tsgd_pkg::REG_ACCEL_PITCH, a1);
		apb_write(tsgd_pkg::REG_ACCEL_YAW, a2);
		apb_write(tsgd_pkg::REG_HALF_PERIOD, hp);
		apb_write(tsgd_pkg::REG_OUTPUT_COUNT, cnt);
	endtask

	task automatic send_word(logic [1:0] cmd, logic [1:0] ch, logic [31:0] val,
			logic [15:0] st);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = cmd;
		s_axis_tdata  = {6'd0, st, val, ch};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(cmd, ch, val, st);
	endtask

	task automatic random_word();
		int          pick;
		logic [1:0]  cmd, ch;
		logic [31:0] val;
		logic [15:0] st;
		pick = $urandom_range(99);
		if (pick < 45)
			cmd = tsgd_pkg::CMD_TICK;
		else if (pick < 70)
			cmd = tsgd_pkg::CMD_SPEED;
		else if (pick < 94)
			cmd = tsgd_pkg::CMD_LAG;
		else
			cmd = CMD_UNKNOWN;
		ch = ($urandom_range(9) == 0) ? CH_INVALID : 2'($urandom_range(2));
		case ($urandom_range(7))
			0: val = 32'h7FFF_FFFF;
			1: val = 32'h8000_0000;
			2, 3: val = 32'($urandom_range(4000000)) - 32'd2000000;
			default: val = $urandom;
		endcase
		st = ($urandom_range(3) == 0) ? 16'($urandom_range(255)) : 16'($urandom);
		send_word(cmd, ch, val, st);
	endtask

	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.compare_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		sb            = new();
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = tsgd_pkg::CMD_TICK;
		m_axis_tready = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, invalid channel, unknown command, tick fields ignored
		write_all(100, 255, 1, 32'hFFFF_FFFF, 0, tsgd_pkg::ACCEL_RST, tsgd_pkg::HALF_RST, 9);
		send_word(tsgd_pkg::CMD_TICK, 2'd0, 32'd0, 16'd0);
		send_word(tsgd_pkg::CMD_LAG, 2'd1, 32'h4000_0000, 16'd0);
		send_word(tsgd_pkg::CMD_LAG, 2'd2, 32'h8000_0000, 16'hFFFF);
		send_word(tsgd_pkg::CMD_LAG, 2'd0, 32'hFFFF_FFFF, 16'd0);
		send_word(tsgd_pkg::CMD_TICK, CH_INVALID, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(tsgd_pkg::CMD_SPEED, 2'd0, 32'h7FFF_FFFF, 16'hFFFF);
		send_word(tsgd_pkg::CMD_SPEED, 2'd1, 32'h8000_0000, 16'hFFFF);
		send_word(tsgd_pkg::CMD_SPEED, 2'd2, 32'h8000_0000, 16'hFFFF);
		send_word(tsgd_pkg::CMD_SPEED, 2'd2, 32'h7FFF_FFFF, 16'd0);
		send_word(tsgd_pkg::CMD_TICK, 2'd2, 32'h5555_AAAA, 16'h1234);
		send_word(tsgd_pkg::CMD_SPEED, CH_INVALID, 32'h1000_0000, 16'hFFFF);
		send_word(tsgd_pkg::CMD_LAG, CH_INVALID, 32'h1234_5678, 16'd0);
		send_word(CMD_UNKNOWN, 2'd0, 32'hFFFF_FFFF, 16'hFFFF);
		send_word(tsgd_pkg::CMD_TICK, 2'd1, 32'd0, 16'd0);
		send_word(tsgd_pkg::CMD_LAG, 2'd0, 32'hC000_0000, 16'd0);
		send_word(tsgd_pkg::CMD_SPEED, 2'd0, 32'h8000_0000, 16'hFFFF);
		send_word(tsgd_pkg::CMD_SPEED, 2'd0, 32'h8000_0000, 16'hFFFF);
		send_word(tsgd_pkg::CMD_TICK, 2'd0, 32'd0, 16'd0);
		send_word(tsgd_pkg::CMD_TICK, 2'd0, 32'd0, 16'd0);
		send_word(tsgd_pkg::CMD_SPEED, 2'd2, 32'hFFFF_FC18, 16'h8000);
		send_word(tsgd_pkg::CMD_TICK, 2'd0, 32'd0, 16'd0);
		drain();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p / 2)
				0: begin
					send_idle_pct  = 37;
					recv_stall_pct = 87;
				end
				1: begin
					send_idle_pct  = 87;
					recv_stall_pct = 37;
				end
				default: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
			endcase
			case (p)
				0: write_all(0, 255, 100, 32'hFFFF_FFFF, 0, $urandom, 32'h7FFF, 9);
				1: write_all(255, 255, 255, $urandom, $urandom, $urandom, 0, 3);
				2: write_all(0, 37, 255, 0, 32'hFFFF_FFFF, $urandom, $urandom, 6);
				3: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom_range(5));
				4: write_all($urandom, $urandom, $urandom, $urandom_range(65535),
					$urandom_range(65535), $urandom_range(65535), 32'h7FFF, 9);
				default: write_all(255, 255, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					$urandom, 15);
			endcase
			repeat (WORDS_PER_PHASE) random_word();
			drain();
		end

		if (sb.errors == 0 && sb.compare_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
